// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle, checked outside reset
`define SIDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property holds in the cycle after, checked outside reset
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sida_pkg.sv =====
// types and constants of the integer to decimal text block
`default_nettype none

package sida_pkg;

  // one ascii character
  typedef logic [7:0] char_t;

  // one bcd digit
  localparam int DIGIT_W = 4;
  typedef logic [DIGIT_W-1:0] digit_t;

  // character codes
  localparam char_t ASCII_ZERO  = 8'h30;
  localparam char_t ASCII_MINUS = 8'h2D;

  // digit adjust threshold and offset of the shift-add-3 step
  localparam digit_t DABBLE_LIMIT = 4'd5;
  localparam digit_t DABBLE_ADD   = 4'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/sida_channels.sv =====
// valid/ready channel interfaces for input values and output characters
`default_nettype none

interface sida_in_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sida_out_if ();
  logic                  valid;
  logic                  ready;
  sida_pkg::char_t       character;
  logic                  last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/signed_int_to_decimal_ascii_top.sv =====
// signed integer to decimal ascii text converter, top level
//
//   channel  dir  payload                    handshake
//   in_ch    in   value (VALUE_WIDTH, signed) valid / ready
//   out_ch   out  character (8), last (1)    valid / ready
//
// each bit of the magnitude passes through the shared shift-add-3 unit,
// then the leading digit is found, then one character per cycle leaves
// through the output register while out_ch is ready.
// a new value is taken only between texts; the last character may still wait.
// reset is synchronous and active low and clears the sequencer and out valid.
`default_nettype none
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sida_in_if.sink         in_ch,
  sida_out_if.source      out_ch
);

  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W      = NUM_DIGITS * sida_pkg::DIGIT_W;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int CNT_W      = $clog2(VALUE_WIDTH);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_LEAD = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic                   neg_r, neg_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sida_pkg::char_t        out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_accept;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] in_bits;
  logic [BCD_W-1:0]       bcd_step;
  logic [IDX_W-1:0]       lead_idx;
  sida_pkg::digit_t       digit_sel;

  // handshakes
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_bits     = in_ch.value;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  // shared shift-add-3 unit
  sida_dabble #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dabble (
    .bcd_i (bcd_r),
    .bit_i (mag_r[VALUE_WIDTH-1]),
    .bcd_o (bcd_step)
  );

  // most significant nonzero digit, zero for a value of zero
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] != '0) begin
        lead_idx = IDX_W'(i);
      end
    end
  end

  // digit under the emit pointer
  assign digit_sel = bcd_r[{idx_r, 2'b00} +: sida_pkg::DIGIT_W];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          neg_nxt   = in_bits[VALUE_WIDTH-1];
          mag_nxt   = in_bits[VALUE_WIDTH-1] ? (~in_bits + 1'b1) : in_bits;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_WIDTH - 1);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = bcd_step;
        mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = ST_LEAD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_LEAD: begin
        idx_nxt   = lead_idx;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            out_char_nxt = sida_pkg::ASCII_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = sida_pkg::ASCII_ZERO + {4'b0000, digit_sel};
            out_last_nxt = (idx_r == '0);
            if (idx_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // checks
  `SIDA_ASSERT_NOW(a_idx_range, clk, rst_n, state_r == ST_EMIT, idx_r <= IDX_W'(NUM_DIGITS - 1), "emit pointer beyond digit count")
  `SIDA_ASSERT_NOW(a_minus_not_last, clk, rst_n, out_valid_r && (out_char_r == sida_pkg::ASCII_MINUS), !out_last_r, "minus sign marked as last character")
  `SIDA_ASSERT_NEXT(a_conv_done, clk, rst_n, (state_r == ST_CONV) && (cnt_r == '0), state_r == ST_LEAD, "conversion did not end after the last bit")

endmodule

`default_nettype wire

// ===== hw/rtl/sida_dabble.sv =====
// one shift-add-3 step of binary to bcd conversion
`default_nettype none

module sida_dabble #(
  parameter int NUM_DIGITS = 10
) (
  input  wire logic [NUM_DIGITS*sida_pkg::DIGIT_W-1:0] bcd_i,
  input  wire logic                                    bit_i,
  output logic      [NUM_DIGITS*sida_pkg::DIGIT_W-1:0] bcd_o
);

  localparam int BCD_W = NUM_DIGITS * sida_pkg::DIGIT_W;

  logic [BCD_W-1:0] adj;

  // add 3 to every digit of 5 or more, all digits side by side
  always_comb begin
    sida_pkg::digit_t d;
    adj = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd_i[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W];
      if (d >= sida_pkg::DABBLE_LIMIT) begin
        adj[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] = d + sida_pkg::DABBLE_ADD;
      end else begin
        adj[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] = d;
      end
    end
  end

  // shift in the next binary bit
  assign bcd_o = {adj[BCD_W-2:0], bit_i};

endmodule

`default_nettype wire
